FILE: design/kfh_pkg.sv
// Shared constants and types for the keyed command frame handler.
package kfh_pkg;

	localparam int KEY_BYTES  = 20;
	localparam int KEY_WORDS  = (KEY_BYTES + 3) / 4;
	localparam int IDX_W      = $clog2(KEY_BYTES + 1);
	localparam int WORD_SEL_W = (KEY_WORDS > 1) ? $clog2(KEY_WORDS) : 1;

	typedef logic [2:0] cfg_idx_t;

	localparam cfg_idx_t REG_KEY_LAST   = cfg_idx_t'(KEY_WORDS - 1);
	localparam cfg_idx_t REG_TICK_LIMIT = cfg_idx_t'(5);

	localparam logic [31:0] KEY_WORD_RST [5] = '{
		32'd1681208161, 32'd1714565222, 32'd1647600486, 32'd1684104761, 32'd862073188
	};
	localparam logic [7:0] TICK_LIMIT_RST = 8'd5;

	typedef enum logic [1:0] {
		CMD_WAKE = 2'd0,
		CMD_BYTE = 2'd1,
		CMD_TICK = 2'd2,
		CMD_NONE = 2'd3
	} cmd_t;

	localparam logic [7:0] ACT_BATT  = 8'h62;
	localparam logic [7:0] ACT_POWER = 8'h70;
	localparam logic [7:0] ACT_RESET = 8'h72;
	localparam logic [7:0] RSP_OK    = 8'h6f;
	localparam logic [7:0] RSP_BAD   = 8'h6b;
	localparam logic [7:0] RSP_DONE  = 8'h61;

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_CMP    = 4'b0010,
		S_CMPEND = 4'b0100,
		S_EMIT   = 4'b1000
	} state_t;

endpackage

FILE: design/keyed_command_frame_handler_top.sv
// Keyed command frame handler: session sequencer, key store and serial key compare.
//
// Usage:
//  - Input beats (s_t*) carry one command each: wake, received byte or timer tick.
//    A wake opens a session; bytes pick an action and fill a 20-byte key store; a tick
//    past session_tick_limit, a battery byte or a byte after a nonzero action's key closes it.
//  - Output beats (m_t*) carry the response bytes of a closed session; m_tlast
//    marks the final byte (one byte, or three for a battery request).
//  - Config beats (cfg_*) write the five key words and the tick limit; cfg_ready
//    is always high. Write only while the block is idle.
// Timing:
//  - A command that does not close the session is taken while s_tready stays high.
//  - Closing with a power or reset action walks the key store through one shared
//    byte comparator, one entry per cycle, then a drain step (S_CMPEND), then the
//    response beat is loaded. Other closes go straight to the emit step. A closing
//    command holds off new input (s_tready low) until its last response is loaded.
//  - The response goes through an output register; a stalled receiver (m_tready
//    low) holds the sequencer in its emit step and s_tready stays low.
// Reset (arst_n low) closes any session, clears the store valid bits and the
// output register, and loads the default key and tick limit.
module keyed_command_frame_handler_top (
	input  logic                  clk,
	input  logic                  arst_n,
	// input stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [23:0]           s_tdata,   // [7:0] rx_byte, [17:8] battery_level, rest 0
	input  logic [2:0]            s_tuser,   // [1:0] command, [2] stop_bit_ok
	// output stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [7:0]            m_tdata,   // [7:0] tx_byte
	output logic [1:0]            m_tuser,   // [0] power_pulse, [1] reset_pulse
	output logic                  m_tlast,   // last
	// configuration writes
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  kfh_pkg::cfg_idx_t     cfg_index,
	input  logic [31:0]           cfg_data
);
	import kfh_pkg::*;

	// config registers
	logic [31:0] key_q [KEY_WORDS];
	logic [7:0]  tick_limit_q;

	// session state
	state_t           state_q;
	logic             in_session_q;
	logic [7:0]       action_q;
	logic [IDX_W-1:0] rem_q;
	logic [7:0]       tick_q;
	logic [9:0]       battery_q;

	// key store: data in a memory, one valid bit per entry (invalid reads as zero)
	logic [7:0]       mem [KEY_BYTES];
	logic             vld_q [KEY_BYTES];

	// compare walk
	logic [IDX_W-1:0] cnt_q;
	logic [7:0]       rd_s1;
	logic             rdv_s1;
	logic [7:0]       key_s1;
	logic             chk_s1;
	logic             mism_q;
	logic [1:0]       resp_q;

	// output register
	logic             m_tvalid_q;
	logic [7:0]       m_tdata_q;
	logic [1:0]       m_tuser_q;
	logic             m_tlast_q;

	// decoded input beat
	cmd_t             cmd;
	logic             stop_ok;
	logic [7:0]       rx;
	logic             s_acc;
	logic [IDX_W-1:0] wr_idx;
	logic [8:0]       tick_nxt;
	logic             fin;
	logic [7:0]       fin_act;
	logic             out_free;

	// response byte for the current emit step
	logic [7:0]       rsp_byte;
	logic             rsp_pw;
	logic             rsp_rs;
	logic             rsp_last;

	assign cmd      = cmd_t'(s_tuser[1:0]);
	assign stop_ok  = s_tuser[2];
	assign rx       = s_tdata[7:0];
	assign s_tready = (state_q == S_IDLE);
	assign s_acc    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign wr_idx   = IDX_W'(KEY_BYTES) - rem_q;
	assign tick_nxt = {1'b0, tick_q} + 9'd1;
	assign out_free = !m_tvalid_q || m_tready;

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

	// does this beat close the session, and with which action
	always_comb begin
		fin     = 1'b0;
		fin_act = action_q;
		if (in_session_q) begin
			unique case (cmd)
				CMD_BYTE: begin
					if (stop_ok && rem_q == '0) begin
						if (action_q == 8'h00) begin
							fin     = (rx == ACT_BATT);
							fin_act = rx;
						end else begin
							fin = 1'b1;
						end
					end
				end
				CMD_TICK: fin = (tick_nxt > {1'b0, tick_limit_q});
				CMD_WAKE, CMD_NONE: fin = 1'b0;
				default: fin = 1'b0;
			endcase
		end
	end

	always_comb begin
		rsp_byte = RSP_DONE;
		rsp_pw   = 1'b0;
		rsp_rs   = 1'b0;
		rsp_last = 1'b1;
		if (action_q == ACT_POWER || action_q == ACT_RESET) begin
			rsp_byte = mism_q ? RSP_BAD : RSP_OK;
			rsp_pw   = !mism_q && (action_q == ACT_POWER);
			rsp_rs   = !mism_q && (action_q == ACT_RESET);
		end else if (action_q == ACT_BATT) begin
			unique case (resp_q)
				2'd0: begin
					rsp_byte = ACT_BATT;
					rsp_last = 1'b0;
				end
				2'd1: begin
					rsp_byte = {6'd0, battery_q[9:8]};
					rsp_last = 1'b0;
				end
				2'd2: rsp_byte = battery_q[7:0];
				default: rsp_byte = battery_q[7:0];
			endcase
		end
	end

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < KEY_WORDS; i++) begin
				key_q[i] <= KEY_WORD_RST[i];
			end
			tick_limit_q <= TICK_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index <= REG_KEY_LAST) begin
				key_q[cfg_index[WORD_SEL_W-1:0]] <= cfg_data;
			end else if (cfg_index == REG_TICK_LIMIT) begin
				tick_limit_q <= cfg_data[7:0];
			end
		end
	end

	// key store memory: write on key bytes, registered read for the compare walk; battery capture
	always_ff @(posedge clk) begin
		if (s_acc && in_session_q && cmd == CMD_BYTE && stop_ok && rem_q != '0) begin
			mem[wr_idx] <= rx;
		end
		if (state_q == S_CMP) begin
			rd_s1  <= mem[cnt_q];
			key_s1 <= key_q[cnt_q[IDX_W-1:2]][8*cnt_q[1:0] +: 8];
		end
		if (s_acc) begin
			battery_q <= s_tdata[17:8];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			in_session_q <= 1'b0;
			action_q     <= '0;
			rem_q        <= '0;
			tick_q       <= '0;
			cnt_q        <= '0;
			rdv_s1       <= 1'b0;
			chk_s1       <= 1'b0;
			mism_q       <= 1'b0;
			resp_q       <= '0;
			m_tvalid_q   <= 1'b0;
			m_tdata_q    <= '0;
			m_tuser_q    <= '0;
			m_tlast_q    <= 1'b0;
			for (int i = 0; i < KEY_BYTES; i++) begin
				vld_q[i] <= 1'b0;
			end
		end else begin
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			// one byte compare per cycle, in the cycle after the read
			chk_s1 <= (state_q == S_CMP);
			if (chk_s1 && ((rdv_s1 ? rd_s1 : 8'h00) != key_s1)) begin
				mism_q <= 1'b1;
			end

			unique case (state_q)
				S_IDLE: begin
					if (s_acc) begin
						if (cmd == CMD_WAKE && !in_session_q) begin
							in_session_q <= 1'b1;
							tick_q       <= '0;
							rem_q        <= '0;
							action_q     <= '0;
						end else if (in_session_q && cmd == CMD_BYTE && stop_ok) begin
							if (rem_q != '0) begin
								vld_q[wr_idx] <= 1'b1;
								rem_q         <= rem_q - 1'b1;
							end else if (action_q == 8'h00) begin
								action_q <= rx;
								if (rx != ACT_BATT) begin
									rem_q <= IDX_W'(KEY_BYTES);
								end
							end
						end else if (in_session_q && cmd == CMD_TICK && !fin) begin
							tick_q <= tick_nxt[7:0];
						end
						if (fin) begin
							resp_q <= '0;
							if (fin_act == ACT_POWER || fin_act == ACT_RESET) begin
								state_q <= S_CMP;
								cnt_q   <= '0;
								mism_q  <= 1'b0;
							end else begin
								state_q <= S_EMIT;
							end
						end
					end
				end
				S_CMP: begin
					rdv_s1 <= vld_q[cnt_q];
					cnt_q  <= cnt_q + 1'b1;
					if (cnt_q == IDX_W'(KEY_BYTES - 1)) begin
						state_q <= S_CMPEND;
					end
				end
				S_CMPEND: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= rsp_byte;
						m_tuser_q  <= {rsp_rs, rsp_pw};
						m_tlast_q  <= rsp_last;
						resp_q     <= resp_q + 1'b1;
						if (rsp_last) begin
							state_q      <= S_IDLE;
							in_session_q <= 1'b0;
							action_q     <= '0;
							rem_q        <= '0;
							tick_q       <= '0;
							for (int i = 0; i < KEY_BYTES; i++) begin
								vld_q[i] <= 1'b0;
							end
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// key byte count never exceeds the key length
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q <= IDX_W'(KEY_BYTES))
		else $error("key byte count out of range");

	// outside a session nothing is armed
	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && !in_session_q) |-> (action_q == 8'h00 && rem_q == '0))
		else $error("stale session state while closed");

	// a pulse only goes out with the accept answer
	a_pulse_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser[0] || m_tuser[1])) |-> (m_tdata == RSP_OK && m_tlast))
		else $error("pulse on a non-accept response");

	// a non-wake beat outside a session produces no work
	a_closed_ignored: assert property (@(posedge clk) disable iff (!arst_n)
		(s_acc && !in_session_q && cmd != CMD_WAKE) |=> (state_q == S_IDLE && !in_session_q))
		else $error("beat outside session changed state");

	// the compare walk stays within the store
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CMP) |-> (cnt_q < IDX_W'(KEY_BYTES)))
		else $error("compare index past key store");

endmodule

FILE: tb/sv/keyed_command_frame_handler_top_test.sv
// Self-checking testbench for the keyed command frame handler: session traffic against a response scoreboard.
module keyed_command_frame_handler_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	import kfh_pkg::*;

	localparam int         WATCHDOG_LIMIT = 2000;  // cycles with no beat on any channel
	localparam int         SETTLE_CYCLES  = 40;    // > compare walk + drain + output register
	localparam int         HOLD_CYCLES    = 300;   // long receiver hold-off in the last phase
	localparam int         REPORT_CAP     = 50;
	localparam int         PHASE_ITEMS    = 55;    // input beats per random phase
	localparam cfg_idx_t   REG_KEY_FIRST  = '0;
	localparam logic [7:0] ACT_NONE       = 8'h00;

	// one response beat as the block should send it
	typedef struct packed {
		logic [7:0] tx_byte;
		logic       power_pulse;
		logic       reset_pulse;
		logic       last;
	} response_t;

	// Session predictor plus the queue of responses still owed by the block.
	class response_scoreboard;
		logic [31:0]      key_word [KEY_WORDS];
		logic [7:0]       tick_limit;
		logic             session_open;
		logic [7:0]       action;
		logic [IDX_W-1:0] remaining;
		logic [7:0]       ticks;
		logic [7:0]       store [KEY_BYTES];
		response_t        awaited [$];

		function new();
			foreach (key_word[w]) key_word[w] = KEY_WORD_RST[w];
			tick_limit   = TICK_LIMIT_RST;
			session_open = 1'b0;
			action       = ACT_NONE;
			remaining    = '0;
			ticks        = '0;
			foreach (store[i]) store[i] = '0;
		endfunction

		function void write_reg(cfg_idx_t idx, logic [31:0] val);
			if (idx <= REG_KEY_LAST)
				key_word[idx] = val;
			else if (idx == REG_TICK_LIMIT)
				tick_limit = val[7:0];
		endfunction

		function logic [7:0] key_byte(int i);
			return key_word[i / 4][8 * (i % 4) +: 8];
		endfunction

		function void push(logic [7:0] tx, logic pw, logic rs, logic last);
			awaited.push_back(response_t'({tx, pw, rs, last}));
		endfunction

		// end of session: answer, then clear the store and the action
		function void close_session(logic [9:0] batt);
			logic key_ok;
			key_ok = 1'b1;
			if (action == ACT_POWER || action == ACT_RESET) begin
				for (int i = 0; i < KEY_BYTES; i++)
					if (store[i] != key_byte(i))
						key_ok = 1'b0;
				if (key_ok)
					push(RSP_OK, action == ACT_POWER, action == ACT_RESET, 1'b1);
				else
					push(RSP_BAD, 1'b0, 1'b0, 1'b1);
			end else if (action == ACT_BATT) begin
				push(ACT_BATT, 1'b0, 1'b0, 1'b0);
				push({6'b0, batt[9:8]}, 1'b0, 1'b0, 1'b0);
				push(batt[7:0], 1'b0, 1'b0, 1'b1);
			end else
				push(RSP_DONE, 1'b0, 1'b0, 1'b1);
			foreach (store[i]) store[i] = '0;
			action       = ACT_NONE;
			remaining    = '0;
			ticks        = '0;
			session_open = 1'b0;
		endfunction

		function void take_command(cmd_t cmd, logic [7:0] rx, logic stop_ok, logic [9:0] batt);
			case (cmd)
				CMD_WAKE: begin
					if (!session_open) begin
						session_open = 1'b1;
						ticks        = '0;
						remaining    = '0;
						action       = ACT_NONE;
					end
				end
				CMD_BYTE: begin
					if (session_open && stop_ok) begin
						if (remaining != 0) begin
							store[KEY_BYTES - int'(remaining)] = rx;
							remaining = remaining - 1'b1;
						end else if (action == ACT_NONE) begin
							// zero byte keeps the action unset but still arms the key bytes
							action = rx;
							if (rx == ACT_BATT)
								close_session(batt);
							else
								remaining = IDX_W'(KEY_BYTES);
						end else
							close_session(batt);
					end
				end
				CMD_TICK: begin
					if (session_open) begin
						if (int'(ticks) + 1 > int'(tick_limit))
							close_session(batt);
						else
							ticks = ticks + 1'b1;
					end
				end
				default: ;
			endcase
		endfunction

		function string check_response(logic [7:0] tx, logic pw, logic rs, logic last);
			response_t want;
			string     msg;
			if (awaited.size() == 0)
				return $sformatf("response with nothing owed: tx_byte %02h", tx);
			want = awaited.pop_front();
			msg  = "";
			if (tx !== want.tx_byte)
				msg = {msg, $sformatf(" tx_byte got %02h want %02h", tx, want.tx_byte)};
			if (pw !== want.power_pulse)
				msg = {msg, $sformatf(" power_pulse got %0b want %0b", pw, want.power_pulse)};
			if (rs !== want.reset_pulse)
				msg = {msg, $sformatf(" reset_pulse got %0b want %0b", rs, want.reset_pulse)};
			if (last !== want.last)
				msg = {msg, $sformatf(" last got %0b want %0b", last, want.last)};
			return msg;
		endfunction

		function int pending();
			return awaited.size();
		endfunction

		function string drop_oldest();
			response_t want;
			want = awaited.pop_front();
			return $sformatf("response never sent: tx_byte %02h last %0b", want.tx_byte, want.last);
		endfunction
	endclass

	// clock, reset, DUT ports; every input known from time zero
	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata   = '0;   // [7:0] rx_byte, [17:8] battery_level
	logic [2:0]  s_tuser   = '0;   // [1:0] command, [2] stop_bit_ok
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [7:0]  m_tdata;          // [7:0] tx_byte
	logic [1:0]  m_tuser;          // [0] power_pulse, [1] reset_pulse
	logic        m_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	cfg_idx_t    cfg_index = '0;
	logic [31:0] cfg_data  = '0;

	response_scoreboard responses;
	int mismatches    = 0;
	int items_sent    = 0;
	int stall_cycles  = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit offering      = 1'b0;  // mirrors what s_tvalid was last set to
	bit hold_req      = 1'b0;
	bit rx_hold       = 1'b0;

	keyed_command_frame_handler_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	task automatic report_mismatch(string msg);
		mismatches++;
		if (mismatches <= REPORT_CAP)
			$display("%0t ns: mismatch:%s", $time, msg);
	endtask

	// Receiver: random stalls, forced low while the long hold-off runs.
	always @(posedge clk) begin
		m_tready <= !rx_hold && ($urandom_range(99) >= recv_idle_pct);
	end

	// Long hold-off, counted here; sender keeps offering so the block backs up.
	initial begin
		wait (hold_req);
		@(posedge clk);
		rx_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rx_hold <= 1'b0;
	end

	// Monitors sample pre-edge values. Output is checked first so that a stray
	// beat cannot consume a response predicted on the same edge.
	always @(posedge clk) begin : watch_streams
		string msg;
		if (arst_n && m_tvalid && m_tready) begin
			msg = responses.check_response(m_tdata, m_tuser[0], m_tuser[1], m_tlast);
			if (msg != "")
				report_mismatch(msg);
		end
		if (arst_n && s_tvalid && s_tready)
			responses.take_command(cmd_t'(s_tuser[1:0]), s_tdata[7:0], s_tuser[2], s_tdata[17:8]);
	end

	// Watchdog: any beat on any channel restarts the count.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			stall_cycles <= 0;
		else if (stall_cycles + 1 >= WATCHDOG_LIMIT) begin
			$display("FAIL");
			$finish;
		end else
			stall_cycles <= stall_cycles + 1;
	end

	// One input beat; random idle cycles ahead of it at the sender's rate.
	task automatic send_item(cmd_t cmd, logic [7:0] rx, logic stop_ok, logic [9:0] batt);
		while ($urandom_range(99) < send_idle_pct) begin
			if (offering) begin
				s_tvalid <= 1'b0;
				offering = 1'b0;
			end
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {6'b0, batt, rx};
		s_tuser  <= {stop_ok, cmd};
		offering = 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		items_sent++;
	endtask

	// Sender stops and waits until every owed response has arrived.
	task automatic wait_drained();
		if (offering) begin
			s_tvalid <= 1'b0;
			offering = 1'b0;
			@(posedge clk);
		end
		while (responses.pending() != 0) @(posedge clk);
	endtask

	task automatic write_cfg(cfg_idx_t idx, logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		responses.write_reg(idx, val);
	endtask

	// Writes all five key words and the tick limit back to back.
	task automatic load_settings(bit rand_key, logic [31:0] fill, logic [7:0] limit);
		for (int w = 0; w < KEY_WORDS; w++)
			write_cfg(REG_KEY_FIRST + cfg_idx_t'(w), rand_key ? $urandom : fill);
		write_cfg(REG_TICK_LIMIT, {24'b0, limit});
		cfg_valid <= 1'b0;
	endtask

	// Filler inside a session that must not close it.
	task automatic send_noise(ref int ticks_sent);
		case ($urandom_range(11))
			0: send_item(CMD_BYTE, 8'($urandom), 1'b0, 10'($urandom));   // bad stop bit
			1: send_item(CMD_NONE, 8'($urandom), 1'($urandom), 10'($urandom));
			2: begin
				if (ticks_sent < int'(responses.tick_limit)) begin
					send_item(CMD_TICK, 8'($urandom), 1'($urandom), 10'($urandom));
					ticks_sent++;
				end
			end
			3: send_item(CMD_WAKE, 8'($urandom), 1'($urandom), 10'($urandom));   // ignored
			default: ;
		endcase
	endtask

	task automatic close_by_ticks(int ticks_sent);
		repeat (int'(responses.tick_limit) + 1 - ticks_sent)
			send_item(CMD_TICK, 8'($urandom), 1'($urandom), 10'($urandom));
	endtask

	// One well-formed session with random content: wake, action, key bytes, close.
	task automatic run_session();
		logic [7:0] act;
		logic [7:0] kb;
		int         ticks_sent;
		int         cut;
		int         flip_at;
		bit         use_key;
		bit         again;
		ticks_sent = 0;
		again      = 1'b0;
		send_item(CMD_WAKE, 8'($urandom), 1'($urandom), 10'($urandom));
		do begin
			case ($urandom_range(9))
				0, 1, 2: act = ACT_POWER;
				3, 4:    act = ACT_RESET;
				5, 6:    act = ACT_BATT;
				7:       act = ACT_NONE;
				default: act = 8'($urandom);
			endcase
			// a second zero action in a row would only repeat the key round
			if (again && act == ACT_NONE)
				act = ACT_POWER;
			if ($urandom_range(5) == 0)
				send_noise(ticks_sent);
			send_item(CMD_BYTE, act, 1'b1, 10'($urandom));
			if (act == ACT_BATT)
				return;
			// sometimes a tick run cuts the key short; only where the limit is low
			cut = (responses.tick_limit <= 8 && $urandom_range(5) == 0) ?
				$urandom_range(KEY_BYTES - 1) : KEY_BYTES;
			flip_at = ($urandom_range(3) == 0) ? $urandom_range(KEY_BYTES - 1) : -1;
			use_key = ($urandom_range(4) != 0);
			for (int i = 0; i < cut; i++) begin
				if ($urandom_range(7) == 0)
					send_noise(ticks_sent);
				kb = use_key ? responses.key_byte(i) : 8'($urandom);
				if (i == flip_at)
					kb ^= 8'(1 << $urandom_range(7));
				send_item(CMD_BYTE, kb, 1'b1, 10'($urandom));
			end
			if (cut < KEY_BYTES) begin
				close_by_ticks(ticks_sent);
				return;
			end
			again = (act == ACT_NONE);
		end while (again);
		if (responses.tick_limit <= 8 && $urandom_range(3) == 0)
			close_by_ticks(ticks_sent);
		else
			send_item(CMD_BYTE, 8'($urandom), 1'b1, 10'($urandom));
	endtask

	// Mostly sessions, some bursts of raw random beats, occasional full drains.
	task automatic run_phase(int items_goal);
		int first_item;
		first_item = items_sent;
		while (items_sent - first_item < items_goal) begin
			if ($urandom_range(7) == 0)
				wait_drained();
			if ($urandom_range(9) == 0)
				repeat (4)
					send_item(cmd_t'($urandom_range(3)), 8'($urandom), 1'($urandom), 10'($urandom));
			else
				run_session();
		end
		wait_drained();
	endtask

	initial begin
		responses = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed, default key and tick limit of 5.
		// outside a session: byte, tick and the unused code are dropped
		send_item(CMD_BYTE, ACT_POWER, 1'b1, 10'h000);
		send_item(CMD_TICK, 8'hff, 1'b1, 10'h3ff);
		send_item(CMD_NONE, 8'h00, 1'b0, 10'h000);
		// open; second wake, bad stop bit and unused code inside are dropped
		send_item(CMD_WAKE, 8'h00, 1'b0, 10'h000);
		send_item(CMD_WAKE, 8'hff, 1'b1, 10'h3ff);
		send_item(CMD_BYTE, ACT_BATT, 1'b0, 10'h3ff);
		send_item(CMD_NONE, 8'hff, 1'b1, 10'h3ff);
		// battery request, full scale then zero
		send_item(CMD_BYTE, ACT_BATT, 1'b1, 10'h3ff);
		send_item(CMD_WAKE, 8'h00, 1'b1, 10'h000);
		send_item(CMD_BYTE, ACT_BATT, 1'b1, 10'h000);
		// no action at all: ticks run past the limit
		send_item(CMD_WAKE, 8'h00, 1'b1, 10'h000);
		repeat (int'(TICK_LIMIT_RST) + 1) send_item(CMD_TICK, 8'h00, 1'b1, 10'h155);
		// reset action, tick run during key bytes; rest of store stays zero
		send_item(CMD_WAKE, 8'h00, 1'b1, 10'h000);
		send_item(CMD_BYTE, ACT_RESET, 1'b1, 10'h2aa);
		send_item(CMD_BYTE, 8'hff, 1'b1, 10'h3ff);
		send_item(CMD_BYTE, 8'h00, 1'b1, 10'h000);
		repeat (int'(TICK_LIMIT_RST) + 1) send_item(CMD_TICK, 8'hff, 1'b0, 10'h3ff);
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);

		// Phase 1: random key, tick limit of 1; sender idles a little, receiver a lot.
		send_idle_pct = 18;
		recv_idle_pct = 65;
		load_settings(1'b1, '0, 8'd1);
		run_phase(PHASE_ITEMS);
		repeat (SETTLE_CYCLES) @(posedge clk);

		// Phase 2: all-ones key, highest tick limit; idling swapped.
		send_idle_pct = 65;
		recv_idle_pct = 18;
		load_settings(1'b0, '1, 8'd255);
		run_phase(PHASE_ITEMS);
		repeat (SETTLE_CYCLES) @(posedge clk);

		// Phase 3: zero key (a short key then matches the cleared store), no idling,
		// long receiver hold-off at the start.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		load_settings(1'b0, '0, 8'($urandom_range(8, 2)));
		hold_req = 1'b1;
		run_phase(PHASE_ITEMS);
		repeat (SETTLE_CYCLES) @(posedge clk);

		while (responses.pending() != 0)
			report_mismatch(responses.drop_oldest());
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

FILE: keyed_command_frame_handler_top.f
design/kfh_pkg.sv
design/keyed_command_frame_handler_top.sv
tb/sv/keyed_command_frame_handler_top_test.sv
